// ----- sv/assert_macros.svh -----
// Assertion macros shared by the rename block.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/rrbt_pkg.sv -----
// Package for the register rename block: stall codes and item structs.
// Used by the rename top, the pop unit, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package rrbt_pkg;
	localparam int LREG_W = 5;
	localparam int PREG_W = 6;
	localparam int TAG_W  = 3;
	localparam int MASK_W = 8;

	typedef enum logic [1:0] {
		STALL_NONE   = 2'd0,
		STALL_FLUSH  = 2'd1,
		STALL_NO_TAG = 2'd2,
		STALL_NO_REG = 2'd3
	} stall_t;

	typedef struct packed {
		logic              flush;
		logic [LREG_W-1:0] src1_reg;
		logic [LREG_W-1:0] src2_reg;
		logic [LREG_W-1:0] dest_reg;
		logic              dest_is_int;
		logic              is_control;
	} req_t;

	typedef struct packed {
		logic [1:0]        stall_reason;
		logic [PREG_W-1:0] src1_preg;
		logic [PREG_W-1:0] src2_preg;
		logic              src1_busy;
		logic              src2_busy;
		logic [PREG_W-1:0] stale_preg;
		logic [PREG_W-1:0] dest_preg;
		logic [LREG_W-1:0] dest_reg_out;
		logic [TAG_W-1:0]  branch_tag;
		logic [MASK_W-1:0] branch_mask;
	} rsp_t;

	// Handshake between the sequencer and the free-ring pop unit.
	typedef struct packed {
		logic start;
	} pop_cmd_t;

	typedef struct packed {
		logic              done;
		logic              ok;
		logic [PREG_W-1:0] preg;
	} pop_sts_t;
endpackage
`default_nettype wire

// ----- sv/rrbt_if.sv -----
// Valid/ready channel carrying one request or result payload.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface rrbt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/register_rename_with_branch_tags.sv -----
// Register rename with branch tags: map table, busy bits, free-ring pop and tag snapshots.
// Each request renames one micro-op and returns exactly one result. A request
// that allocates nothing has its result registered at accept. One that
// allocates waits on the pop unit, which walks the free ring one entry at a
// time; a control op that takes a tag also copies the map, entry by entry
// (LOGICAL_REGS entries), into the snapshot memory. After reset the free ring
// is filled by a sweep during which no request is taken. Depends on rrbt_pkg,
// rrbt_if, rrbt_pop, rrbt_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module register_rename_with_branch_tags #(
	parameter int PHYS_REGS    = 64,
	parameter int LOGICAL_REGS = 32,
	parameter int BRANCH_TAGS  = 8
) (
	input  wire clk,
	input  wire arst_n,
	rrbt_if.sink   req,
	rrbt_if.source rsp
);
	import rrbt_pkg::*;
	localparam int PW = $clog2(PHYS_REGS);
	localparam int LW = (LOGICAL_REGS > 1) ? $clog2(LOGICAL_REGS) : 1;
	localparam int TW = (BRANCH_TAGS > 1) ? $clog2(BRANCH_TAGS) : 1;
	localparam logic [BRANCH_TAGS-1:0] TAG_FULL = '1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POP  = 5'b00010,
		S_WAIT = 5'b00100,
		S_SNAP = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                  state_q;
	req_t                    op_q;
	rsp_t                    res_q;
	logic                    out_valid_q;
	logic [PW-1:0]           map_q [LOGICAL_REGS];
	logic [PHYS_REGS-1:0]    busy_q;
	logic [BRANCH_TAGS-1:0]  active_q;
	logic [BRANCH_TAGS-1:0]  before_q;
	logic [PHYS_REGS-1:0]    alloc_bits_q [BRANCH_TAGS];
	logic [TW-1:0]           tag_q;
	logic                    got_tag_q;
	logic [LW:0]             snap_idx_q;
	logic                    ready_ok_q;
	logic [PHYS_REGS-1:0]    boot_q;
	pop_cmd_t                pop_cmd;
	pop_sts_t                pop_sts;
	logic                    accept;
	logic [TW-1:0]           free_tag;
	logic                    tag_found;
	logic [PREG_W-1:0]       p1, p2, stale;
	logic                    in_alloc;
	rsp_t                    acc_res;
	logic                    snap_we;
	logic [TW+LW-1:0]        snap_waddr;
	logic [PW-1:0]           snap_wdata;
	logic [PW-1:0]           snap_rdata;
	logic [LW-1:0]           snap_lreg;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q && ready_ok_q;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = res_q;

	// Lowest free tag, a short priority scan.
	always_comb begin
		free_tag  = '0;
		tag_found = 1'b0;
		for (int t = BRANCH_TAGS - 1; t >= 0; t--) begin
			if (!active_q[t]) begin
				free_tag  = TW'(t);
				tag_found = 1'b1;
			end
		end
	end

	// Map lookups for sources and the stale destination.
	always_comb begin
		p1 = (32'(req.data.src1_reg) < LOGICAL_REGS) ?
			PREG_W'(map_q[LW'(req.data.src1_reg)]) : '0;
		p2 = (32'(req.data.src2_reg) < LOGICAL_REGS) ?
			PREG_W'(map_q[LW'(req.data.src2_reg)]) : '0;
		stale = (32'(req.data.dest_reg) < LOGICAL_REGS) ?
			PREG_W'(map_q[LW'(req.data.dest_reg)]) : '0;
		in_alloc = req.data.dest_is_int && req.data.dest_reg != '0 &&
			32'(req.data.dest_reg) < LOGICAL_REGS;
	end

	// Result fields known at accept time.
	always_comb begin
		acc_res = '0;
		if (req.data.flush) begin
			acc_res.stall_reason = STALL_FLUSH;
		end else if (req.data.is_control && (active_q == TAG_FULL || !tag_found)) begin
			acc_res.stall_reason = STALL_NO_TAG;
		end else begin
			acc_res.stall_reason = STALL_NONE;
			acc_res.src1_preg    = p1;
			acc_res.src2_preg    = p2;
			acc_res.src1_busy    = (p1 != '0) && busy_q[PW'(p1)];
			acc_res.src2_busy    = (p2 != '0) && busy_q[PW'(p2)];
			acc_res.stale_preg   = stale;
			acc_res.branch_tag   = req.data.is_control ? TAG_W'(free_tag) : '0;
			acc_res.branch_mask  = MASK_W'(active_q);
			if (in_alloc) begin
				acc_res.dest_reg_out = req.data.dest_reg;
			end
		end
	end

	assign pop_cmd.start = (state_q == S_POP);
	rrbt_pop #(.PHYS_REGS(PHYS_REGS)) u_pop (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pop_cmd),
		.sts    (pop_sts)
	);

	// Snapshot memory: one row of LOGICAL_REGS entries per tag; never read here.
	assign snap_lreg  = snap_idx_q[LW-1:0];
	assign snap_we    = (state_q == S_SNAP);
	assign snap_waddr = {tag_q, snap_lreg};
	assign snap_wdata = (snap_lreg == '0) ? '0 : map_q[snap_lreg];
	rrbt_ram #(.WIDTH(PW), .DEPTH(BRANCH_TAGS * (1 << LW))) u_snap (
		.clk   (clk),
		.we    (snap_we),
		.waddr (snap_waddr),
		.wdata (snap_wdata),
		.raddr (snap_waddr),
		.rdata (snap_rdata)
	);

	// Sequencer: lookup, optional pop, optional snapshot copy, result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			busy_q      <= '0;
			active_q    <= '0;
			for (int i = 0; i < LOGICAL_REGS; i++) map_q[i] <= '0;
			for (int t = 0; t < BRANCH_TAGS; t++) alloc_bits_q[t] <= '0;
			ready_ok_q  <= 1'b0;
			boot_q      <= '0;
			got_tag_q   <= 1'b0;
			snap_idx_q  <= '0;
			op_q        <= '0;
			res_q       <= '0;
			before_q    <= '0;
			tag_q       <= '0;
		end else begin
			// Hold off requests while the pop unit fills the ring.
			boot_q <= {boot_q[PHYS_REGS-2:0], 1'b1};
			if (boot_q[PHYS_REGS-1]) ready_ok_q <= 1'b1;
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= req.data;
						before_q  <= active_q;
						tag_q     <= free_tag;
						got_tag_q <= req.data.is_control;
						res_q     <= acc_res;
						if (req.data.flush) begin
							out_valid_q <= 1'b1;
						end else if (req.data.is_control &&
								(active_q == TAG_FULL || !tag_found)) begin
							out_valid_q <= 1'b1;
						end else begin
							if (in_alloc) begin
								state_q <= S_POP;
							end else if (req.data.is_control) begin
								snap_idx_q <= '0;
								state_q    <= S_SNAP;
							end else begin
								out_valid_q <= 1'b1;
							end
						end
					end
				end
				S_POP: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (pop_sts.done) begin
						if (!pop_sts.ok) begin
							res_q       <= '{stall_reason: STALL_NO_REG, default: '0};
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							busy_q[PW'(pop_sts.preg)] <= 1'b1;
							map_q[LW'(op_q.dest_reg)] <= PW'(pop_sts.preg);
							res_q.dest_preg <= pop_sts.preg;
							for (int t = 0; t < BRANCH_TAGS; t++)
								if (before_q[t]) alloc_bits_q[t][PW'(pop_sts.preg)] <= 1'b1;
							if (got_tag_q) begin
								snap_idx_q <= '0;
								state_q    <= S_SNAP;
							end else begin
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						end
					end
				end
				S_SNAP: begin
					snap_idx_q <= snap_idx_q + 1'b1;
					if (snap_idx_q == (LW+1)'(LOGICAL_REGS - 1)) begin
						alloc_bits_q[tag_q] <= '0;
						active_q[tag_q]     <= 1'b1;
						out_valid_q         <= 1'b1;
						state_q             <= S_OUT;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_no_accept_busy, clk, arst_n, accept |-> state_q == S_IDLE, "request taken while busy")
	`ASSERT_CLK(a_stall_fields, clk, arst_n, (rsp.valid && res_q.stall_reason != STALL_NONE) |-> res_q.dest_preg == '0, "stall with allocation")
	`ASSERT_CLK(a_tag_grows, clk, arst_n, (active_q & $past(active_q)) == $past(active_q), "tag released")
	`ASSERT_CLK(a_snap_unused, clk, arst_n, snap_we |-> ($countones(snap_rdata) <= PW), "snapshot width")
endmodule
`default_nettype wire

// ----- sv/rrbt_ram.sv -----
// Generic single-port-write RAM with one registered read port.
// Standalone; used for the free ring and the map snapshots.
`timescale 1ns / 1ps
`default_nettype none
module rrbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/rrbt_pop.sv -----
// Free-ring pop unit: walks the ring one entry at a time, skipping invalid ones.
// Depends on rrbt_pkg and rrbt_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rrbt_pop #(
	parameter int PHYS_REGS = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire rrbt_pkg::pop_cmd_t  cmd,
	output rrbt_pkg::pop_sts_t       sts
);
	import rrbt_pkg::*;
	localparam int PW = $clog2(PHYS_REGS);
	localparam int CW = $clog2(PHYS_REGS + 1);

	typedef enum logic [2:0] {
		P_IDLE = 3'b001,
		P_READ = 3'b010,
		P_TEST = 3'b100
	} pstate_t;

	pstate_t         state_q;
	logic [PW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   tries_q;
	logic            init_q;
	logic [PW-1:0]   init_addr_q;
	logic [PW-1:0]   ram_waddr;
	logic [PW-1:0]   ram_wdata;
	logic [PW-1:0]   ram_rdata;
	logic            valid_cand;

	// Ring storage; filled with 1..PHYS_REGS-1 by a sweep after reset.
	assign ram_waddr = init_addr_q;
	assign ram_wdata = (init_addr_q == PW'(PHYS_REGS - 1)) ? '0 : init_addr_q + 1'b1;
	rrbt_ram #(.WIDTH(PW), .DEPTH(PHYS_REGS)) u_ring (
		.clk   (clk),
		.we    (init_q),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// Entries are PW bits wide, so only zero is invalid.
	assign valid_cand = (ram_rdata != '0);

	// Pop sequencer: read one entry, then test it and advance the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= P_IDLE;
			head_q      <= '0;
			count_q     <= CW'(PHYS_REGS - 1);
			tries_q     <= '0;
			init_q      <= 1'b1;
			init_addr_q <= '0;
		end else begin
			if (init_q) begin
				init_addr_q <= init_addr_q + 1'b1;
				if (init_addr_q == PW'(PHYS_REGS - 1)) begin
					init_q <= 1'b0;
				end
			end
			case (state_q)
				P_IDLE: begin
					if (cmd.start) begin
						tries_q <= '0;
						state_q <= P_READ;
					end
				end
				P_READ: begin
					state_q <= P_TEST;
				end
				P_TEST: begin
					if (count_q == '0 || tries_q == CW'(PHYS_REGS)) begin
						state_q <= P_IDLE;
					end else begin
						head_q  <= head_q + 1'b1;
						count_q <= count_q - 1'b1;
						tries_q <= tries_q + 1'b1;
						state_q <= valid_cand ? P_IDLE : P_READ;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	// Status back to the sequencer.
	always_comb begin
		sts.done = 1'b0;
		sts.ok   = 1'b0;
		sts.preg = '0;
		if (state_q == P_TEST) begin
			if (count_q == '0 || tries_q == CW'(PHYS_REGS)) begin
				sts.done = 1'b1;
			end else if (valid_cand) begin
				sts.done = 1'b1;
				sts.ok   = 1'b1;
				sts.preg = PREG_W'(ram_rdata);
			end
		end
	end

	`ASSERT_CLK(a_count_range, clk, arst_n, count_q <= CW'(PHYS_REGS - 1), "free count overflow")
	`ASSERT_CLK(a_ok_nonzero, clk, arst_n, sts.ok |-> sts.preg != '0, "popped register 0")
	`ASSERT_CLK(a_no_start_in_init, clk, arst_n, init_q |-> state_q == P_IDLE, "pop during ring fill")
endmodule
`default_nettype wire

// ----- sim/register_rename_with_branch_tags_checker.sv -----
// Result checker for the register rename block: predicts each result from the requests it sees.
// Depends on rrbt_pkg; watches both channels and counts mismatches.
`timescale 1ns / 1ps
`default_nettype none
module register_rename_with_branch_tags_checker (
	input  wire clk,
	input  wire arst_n,
	input  wire req_valid,
	input  wire req_ready,
	input  wire rrbt_pkg::req_t req_data,
	input  wire rsp_valid,
	input  wire rsp_ready,
	input  wire rrbt_pkg::rsp_t rsp_data,
	output int  fail_count,
	output int  pending
);
	import rrbt_pkg::*;
	localparam int NPREG = 64;
	localparam int NLREG = 32;
	localparam int NTAG  = 8;

	// Rename state that the predictor keeps in step with the block.
	logic [PREG_W-1:0] ring [NPREG];
	int                ring_head;
	int                ring_left;
	logic              busy [NPREG];
	logic [PREG_W-1:0] rename_map [NLREG];
	logic [MASK_W-1:0] tags_active;
	rsp_t              expected_results[$];

	// Compute the result of one request and update the predicted state.
	function automatic rsp_t rename_op(req_t r);
		rsp_t o;
		int tag;
		logic [MASK_W-1:0] prior;
		logic [PREG_W-1:0] newreg;
		logic found;
		o = '0;
		tag = -1;
		found = 1'b0;
		newreg = '0;
		if (r.flush) begin
			o.stall_reason = STALL_FLUSH;
			return o;
		end
		prior = tags_active;
		if (r.is_control) begin
			for (int t = NTAG - 1; t >= 0; t--)
				if (!prior[t]) tag = t;
			if (tag < 0) begin
				o.stall_reason = STALL_NO_TAG;
				return o;
			end
		end
		o.src1_preg = rename_map[r.src1_reg];
		o.src2_preg = rename_map[r.src2_reg];
		o.stale_preg = rename_map[r.dest_reg];
		o.src1_busy = (o.src1_preg != 0) && busy[o.src1_preg];
		o.src2_busy = (o.src2_preg != 0) && busy[o.src2_preg];
		if (r.dest_is_int && r.dest_reg != 0) begin
			for (int k = 0; k < NPREG && !found && ring_left > 0; k++) begin
				newreg = ring[ring_head];
				ring_head = (ring_head + 1) % NPREG;
				ring_left--;
				if (newreg != 0) found = 1'b1;
			end
			if (!found) begin
				o = '0;
				o.stall_reason = STALL_NO_REG;
				return o;
			end
			busy[newreg] = 1'b1;
			rename_map[r.dest_reg] = newreg;
			o.dest_preg = newreg;
			o.dest_reg_out = r.dest_reg;
		end
		if (tag >= 0) begin
			tags_active[tag] = 1'b1;
			o.branch_tag = tag[TAG_W-1:0];
		end
		o.stall_reason = STALL_NONE;
		o.branch_mask = prior;
		return o;
	endfunction

	// Predict on each accepted request and compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NPREG; i++) begin
				ring[i] = (i + 1 < NPREG) ? PREG_W'(i + 1) : '0;
				busy[i] = 1'b0;
			end
			for (int i = 0; i < NLREG; i++) rename_map[i] = '0;
			ring_head = 0;
			ring_left = NPREG - 1;
			tags_active = '0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("Unexpected result %p", rsp_data);
				end else begin
					want = expected_results.pop_front();
					if (rsp_data !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Mismatch: expected %p, got %p", want, rsp_data);
					end
				end
			end
			if (req_valid && req_ready) expected_results.push_back(rename_op(req_data));
			pending = expected_results.size();
		end
	end
endmodule
`default_nettype wire

// ----- sim/register_rename_with_branch_tags_test.sv -----
// Top of the rename testbench: clock, reset, request stimulus and verdict.
// Depends on rrbt_pkg, rrbt_if, the rename block and its checker.
`timescale 1ns / 1ps
`default_nettype none
module register_rename_with_branch_tags_test;
	import rrbt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	logic stim_done = 1'b0;

	rrbt_if #(.T(req_t)) req ();
	rrbt_if #(.T(rsp_t)) rsp ();

	register_rename_with_branch_tags DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	register_rename_with_branch_tags_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send one request after a random gap, then hold it until taken.
	task automatic send_request(req_t r);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	function automatic req_t random_request(int flush_pct, int ctl_pct);
		req_t r;
		r = req_t'($urandom);
		r.flush = ($urandom_range(0, 99) < flush_pct);
		r.is_control = ($urandom_range(0, 99) < ctl_pct);
		return r;
	endfunction

	// Result side: draw a stall length for every result.
	initial begin
		int waitc;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			waitc = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0) waitc = 0;
			repeat (waitc) begin
				rsp.ready <= 1'b0;
				@(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// Stimulus: directed corners first, then random ops.
	initial begin
		req_t r;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request('{1'b1, 5'd31, 5'd31, 5'd31, 1'b1, 1'b1});
		send_request('{1'b0, 5'd0, 5'd0, 5'd0, 1'b1, 1'b0});
		send_request('{1'b0, 5'd0, 5'd31, 5'd31, 1'b1, 1'b0});
		send_request('{1'b0, 5'd31, 5'd0, 5'd5, 1'b0, 1'b0});
		send_request('{1'b0, 5'd31, 5'd31, 5'd31, 1'b1, 1'b1});
		send_request('{1'b0, 5'd5, 5'd31, 5'd1, 1'b1, 1'b0});
		// Use up all tags so that a control op stalls for want of one.
		for (int i = 0; i < 9; i++)
			send_request('{1'b0, 5'(i), 5'(i + 1), 5'(i + 2), i[0], 1'b1});
		send_request('{1'b1, 5'd1, 5'd2, 5'd3, 1'b1, 1'b1});
		// Random ops; the free ring runs dry after 63 allocations.
		for (int i = 0; i < 650; i++) begin
			r = random_request(8, 10);
			send_request(r);
		end
		req.valid <= 1'b0;
		stim_done <= 1'b1;
	end

	// Watchdog and verdict.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL register_rename_with_branch_tags");
				$finish;
			end
			if (stim_done && pending == 0) begin
				repeat (300) @(posedge clk);
				if (fail_count == 0 && pending == 0) begin
					$display("PASS register_rename_with_branch_tags");
				end else begin
					$display("FAIL register_rename_with_branch_tags");
				end
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
